/* rtl/scbr_pkg.sv */
// shared types and codes for the size class block recycler
`default_nettype none
package scbr_pkg;

	localparam int QDEPTH = 2;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_REUSED    = 3'd0,
		ST_NEW       = 3'd1,
		ST_LARGE     = 3'd2,
		ST_NO_HANDLE = 3'd3,
		ST_REJECT    = 3'd4
	} alloc_status_t;

	typedef enum logic {
		BK_IDLE,
		BK_FINISH
	} back_state_t;

	// classified request as it travels from front to back
	typedef struct packed {
		func_t       func;
		logic        cached;
		logic [6:0]  cls;
		logic [7:0]  fh;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

/* rtl/size_class_block_recycler.sv */
// top level of the size class block recycler
//
//  channel   signals                              handshake
//  request   func, req_size, free_handle          start, taken when busy is low
//  result    status, handle, size_class           done, one cycle, no back-pressure
//
// the back end pops a request in BK_IDLE while reading the link and class memories
// at the list head or freed handle, and rewrites heads and entries in BK_FINISH;
// it pops the next request only after that. a request passes the front register,
// a queue entry and the back request register. the front register and a 2-entry queue
// take up to 3 requests ahead of the back end, after which busy rises.
// reset empties all lists and the queue; no clearing pass is needed.
`default_nettype none
module size_class_block_recycler import scbr_pkg::*; #(
	parameter int MAX_BLOCKS       = 256,
	parameter int MIN_CLASS        = 12,
	parameter int MAX_CACHED_CLASS = 19
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] req_size,
	input  wire logic [7:0]  free_handle,
	output logic             done,
	output logic [2:0]       status,
	output logic [7:0]       handle,
	output logic [6:0]       size_class
);

	q_stat_t qstat;
	logic    push, pop;
	req_t    push_req, head_req;

	scbr_front #(
		.MIN_CLASS        (MIN_CLASS),
		.MAX_CACHED_CLASS (MAX_CACHED_CLASS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.req_size    (req_size),
		.free_handle (free_handle),
		.qstat       (qstat),
		.push        (push),
		.push_req    (push_req)
	);

	scbr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.qstat    (qstat),
		.head_req (head_req)
	);

	scbr_back #(
		.MAX_BLOCKS       (MAX_BLOCKS),
		.MIN_CLASS        (MIN_CLASS),
		.MAX_CACHED_CLASS (MAX_CACHED_CLASS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head_req   (head_req),
		.pop        (pop),
		.done       (done),
		.status     (status),
		.handle     (handle),
		.size_class (size_class)
	);

endmodule
`default_nettype wire

/* rtl/scbr_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module scbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/scbr_front.sv */
// front end: takes requests and works out the size class
`default_nettype none
module scbr_front import scbr_pkg::*; #(
	parameter int MIN_CLASS        = 12,
	parameter int MAX_CACHED_CLASS = 19
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] req_size,
	input  wire logic [7:0]  free_handle,
	input  wire q_stat_t     qstat,
	output logic             push,
	output req_t             push_req
);

	logic        vld_s1;
	logic        func_s1;
	logic [31:0] size_s1;
	logic [7:0]  fh_s1;
	logic [31:0] size_m1;
	logic [6:0]  fls;
	logic [6:0]  cls;
	logic        accept;

	assign busy   = vld_s1 & qstat.full;
	assign accept = start & ~busy;
	assign push   = vld_s1 & ~qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			size_s1 <= req_size;
			fh_s1   <= free_handle;
		end
	end

	assign size_m1 = size_s1 - 32'd1;

	always_comb begin
		fls = '0;
		for (int i = 0; i < 32; i++) begin
			if (size_m1[i]) begin
				fls = 7'(i + 1);
			end
		end
	end

	// size zero gets class 64, as if size-1 wrapped to an all-ones 64-bit value
	always_comb begin
		if (size_s1 == '0) begin
			cls = 7'd64;
		end else if (fls < 7'(MIN_CLASS)) begin
			cls = 7'(MIN_CLASS);
		end else begin
			cls = fls;
		end
	end

	always_comb begin
		push_req.func   = func_t'(func_s1);
		push_req.cached = (cls <= 7'(MAX_CACHED_CLASS));
		push_req.cls    = cls;
		push_req.fh     = fh_s1;
	end

endmodule
`default_nettype wire

/* rtl/scbr_queue.sv */
// short request queue between front and back
`default_nettype none
module scbr_queue import scbr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_req,
	input  wire logic pop,
	output q_stat_t   qstat,
	output req_t      head_req
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	req_t          ent_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign qstat.full  = (cnt_q == CW'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head_req    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_req;
		end
	end

endmodule
`default_nettype wire

/* rtl/scbr_back.sv */
// back end: free lists, handle pool and result register
`default_nettype none
module scbr_back import scbr_pkg::*; #(
	parameter int MAX_BLOCKS       = 256,
	parameter int MIN_CLASS        = 12,
	parameter int MAX_CACHED_CLASS = 19
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_stat_t qstat,
	input  wire req_t  head_req,
	output logic       pop,
	output logic       done,
	output logic [2:0] status,
	output logic [7:0] handle,
	output logic [6:0] size_class
);

	localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int HW  = $clog2(MAX_BLOCKS + 1);
	localparam int NC  = MAX_CACHED_CLASS - MIN_CLASS + 1;
	localparam int CIW = (NC > 1) ? $clog2(NC) : 1;
	localparam int SW  = $clog2(NC + 1);
	localparam int XW  = (AW > 8) ? AW : 8;
	localparam logic [HW-1:0] NULL_H = HW'(MAX_BLOCKS);

	back_state_t    st_q, st_nxt;
	req_t           cur_q;
	logic [HW-1:0]  class_head_q [NC];
	logic [HW-1:0]  spare_head_q;
	logic [HW-1:0]  fresh_q;
	logic [MAX_BLOCKS-1:0] blk_busy_q;
	logic [HW-1:0]  busy_cnt_q [NC + 1];
	logic [HW-1:0]  idle_cnt_q [NC];

	logic [AW-1:0]  link_raddr, link_waddr, cls_raddr, bct_waddr;
	logic [HW-1:0]  link_rdata, link_wdata;
	logic [6:0]     cls_rdata, bct_wdata;
	logic           link_we, bct_we;

	logic           ch_we, sp_we, fr_inc, busy_set, busy_clr;
	logic [CIW-1:0] ch_idx;
	logic [HW-1:0]  ch_val, sp_val;
	logic [AW-1:0]  busy_idx;
	logic           bc_inc, bc_dec, ic_inc, ic_dec;
	logic [SW-1:0]  bc_slot;
	logic [CIW-1:0] ic_slot;
	logic           res_vld;
	alloc_status_t  res_status;
	logic [7:0]     res_handle;
	logic [6:0]     res_cls;

	logic [CIW-1:0] hd_c, cur_c, rc_c;
	logic [XW-1:0]  hd_fx, cur_fx;
	logic [AW-1:0]  fidx;
	logic           fh_ok, rc_cached, reuse_rd, got;
	logic [HW-1:0]  h;

	function automatic logic [CIW-1:0] cidx(input logic [6:0] c);
		logic [6:0] d;
		d    = c - 7'(MIN_CLASS);
		cidx = d[CIW-1:0];
	endfunction

	scbr_ram #(.WIDTH(HW), .DEPTH(MAX_BLOCKS)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	scbr_ram #(.WIDTH(7), .DEPTH(MAX_BLOCKS)) u_cls (
		.clk   (clk),
		.we    (bct_we),
		.waddr (bct_waddr),
		.wdata (bct_wdata),
		.raddr (cls_raddr),
		.rdata (cls_rdata)
	);

	// read side: addresses are set up while the next request is popped
	assign hd_c  = cidx(head_req.cls);
	assign hd_fx = XW'(head_req.fh);
	assign reuse_rd = (head_req.func == FUNC_ALLOC) && head_req.cached &&
		(class_head_q[hd_c] != NULL_H);

	always_comb begin
		if (reuse_rd) begin
			link_raddr = class_head_q[hd_c][AW-1:0];
		end else if (spare_head_q != NULL_H) begin
			link_raddr = spare_head_q[AW-1:0];
		end else begin
			link_raddr = '0;
		end
		cls_raddr = hd_fx[AW-1:0];
	end

	always_comb begin
		st_nxt = st_q;
		pop    = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop    = 1'b1;
					st_nxt = BK_FINISH;
				end
			end
			BK_FINISH: begin
				st_nxt = BK_IDLE;
			end
			default: begin
				st_nxt = BK_IDLE;
			end
		endcase
	end

	assign cur_c  = cidx(cur_q.cls);
	assign cur_fx = XW'(cur_q.fh);
	assign fidx   = cur_fx[AW-1:0];
	assign fh_ok  = (32'(cur_q.fh) < 32'(MAX_BLOCKS)) && blk_busy_q[fidx];
	assign rc_cached = (cls_rdata >= 7'(MIN_CLASS)) && (cls_rdata <= 7'(MAX_CACHED_CLASS));
	assign rc_c   = cidx(cls_rdata);

	// update side: list heads, pool and counts change in the finish state
	always_comb begin
		ch_we = 1'b0; ch_idx = '0; ch_val = '0;
		sp_we = 1'b0; sp_val = '0; fr_inc = 1'b0;
		busy_set = 1'b0; busy_clr = 1'b0; busy_idx = '0;
		link_we = 1'b0; link_waddr = '0; link_wdata = '0;
		bct_we = 1'b0; bct_waddr = '0; bct_wdata = '0;
		bc_inc = 1'b0; bc_dec = 1'b0; bc_slot = '0;
		ic_inc = 1'b0; ic_dec = 1'b0; ic_slot = '0;
		res_vld = 1'b0; res_status = ST_REUSED; res_handle = '0; res_cls = '0;
		got = 1'b0; h = '0;
		if (st_q == BK_FINISH) begin
			res_vld = 1'b1;
			if (cur_q.func == FUNC_ALLOC) begin
				res_cls = cur_q.cls;
				if (cur_q.cached && (class_head_q[cur_c] != NULL_H)) begin
					h          = class_head_q[cur_c];
					ch_we      = 1'b1;
					ch_idx     = cur_c;
					ch_val     = link_rdata;
					busy_set   = 1'b1;
					busy_idx   = h[AW-1:0];
					bc_inc     = 1'b1;
					bc_slot    = SW'(cur_c);
					ic_dec     = 1'b1;
					ic_slot    = cur_c;
					res_status = ST_REUSED;
					res_handle = 8'(h);
				end else begin
					if (spare_head_q != NULL_H) begin
						h      = spare_head_q;
						sp_we  = 1'b1;
						sp_val = link_rdata;
						got    = 1'b1;
					end else if (fresh_q < NULL_H) begin
						h      = fresh_q;
						fr_inc = 1'b1;
						got    = 1'b1;
					end
					if (got) begin
						bct_we     = 1'b1;
						bct_waddr  = h[AW-1:0];
						bct_wdata  = cur_q.cls;
						busy_set   = 1'b1;
						busy_idx   = h[AW-1:0];
						bc_inc     = 1'b1;
						res_handle = 8'(h);
						if (cur_q.cached) begin
							bc_slot    = SW'(cur_c);
							res_status = ST_NEW;
						end else begin
							bc_slot    = SW'(NC);
							res_status = ST_LARGE;
						end
					end else begin
						res_status = ST_NO_HANDLE;
						res_handle = '0;
					end
				end
			end else begin
				res_handle = cur_q.fh;
				if (!fh_ok) begin
					res_status = ST_REJECT;
					res_cls    = '0;
				end else begin
					res_cls    = cls_rdata;
					busy_clr   = 1'b1;
					busy_idx   = fidx;
					link_we    = 1'b1;
					link_waddr = fidx;
					bc_dec     = 1'b1;
					if (!rc_cached) begin
						link_wdata = spare_head_q;
						sp_we      = 1'b1;
						sp_val     = HW'(cur_fx);
						bc_slot    = SW'(NC);
						res_status = ST_LARGE;
					end else begin
						link_wdata = class_head_q[rc_c];
						ch_we      = 1'b1;
						ch_idx     = rc_c;
						ch_val     = HW'(cur_fx);
						bc_slot    = SW'(rc_c);
						ic_inc     = 1'b1;
						ic_slot    = rc_c;
						res_status = ST_REUSED;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= BK_IDLE;
			spare_head_q <= NULL_H;
			fresh_q      <= '0;
			blk_busy_q   <= '0;
			done         <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				class_head_q[i] <= NULL_H;
				idle_cnt_q[i]   <= '0;
			end
			for (int i = 0; i < NC + 1; i++) begin
				busy_cnt_q[i] <= '0;
			end
		end else begin
			st_q <= st_nxt;
			done <= res_vld;
			if (ch_we) begin
				class_head_q[ch_idx] <= ch_val;
			end
			if (sp_we) begin
				spare_head_q <= sp_val;
			end
			if (fr_inc) begin
				fresh_q <= fresh_q + HW'(1);
			end
			if (busy_set) begin
				blk_busy_q[busy_idx] <= 1'b1;
			end else if (busy_clr) begin
				blk_busy_q[busy_idx] <= 1'b0;
			end
			if (bc_inc) begin
				busy_cnt_q[bc_slot] <= busy_cnt_q[bc_slot] + HW'(1);
			end else if (bc_dec) begin
				busy_cnt_q[bc_slot] <= busy_cnt_q[bc_slot] - HW'(1);
			end
			if (ic_inc) begin
				idle_cnt_q[ic_slot] <= idle_cnt_q[ic_slot] + HW'(1);
			end else if (ic_dec) begin
				idle_cnt_q[ic_slot] <= idle_cnt_q[ic_slot] - HW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_req;
		end
		if (res_vld) begin
			status     <= res_status;
			handle     <= res_handle;
			size_class <= res_cls;
		end
	end

endmodule
`default_nettype wire

/* tb/size_class_block_recycler_checker.sv */
// checker for the size class block recycler: predicts each result and compares it
`default_nettype none
module size_class_block_recycler_checker import scbr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        func,
	input  wire logic [31:0] req_size,
	input  wire logic [7:0]  free_handle,
	input  wire logic        done,
	input  wire logic [2:0]  status,
	input  wire logic [7:0]  handle,
	input  wire logic [6:0]  size_class,
	output int               pending,
	output int               errors
);

	localparam int NBLK = 256;
	localparam int CMIN = 12;
	localparam int CMAX = 19;
	localparam logic [8:0] NULL_H = 9'd256;

	typedef struct packed {
		alloc_status_t status;
		logic [7:0]    handle;
		logic [6:0]    cls;
	} outcome_t;

	logic [8:0] next_link [NBLK];
	logic [6:0] blk_class [NBLK];
	logic       blk_held  [NBLK];
	logic [8:0] list_head [CMAX-CMIN+1];
	logic [8:0] spare_top;
	logic [8:0] fresh_next;
	outcome_t   outcome_q [$];

	// class is max(12, position of highest set bit of size-1), size-1 wrapping at 64 bits
	function automatic logic [6:0] size_to_class(input logic [31:0] sz);
		logic [63:0] v;
		int n;
		v = {32'b0, sz} - 64'd1;
		n = 0;
		for (int b = 0; b < 64; b++)
			if (v[b]) n = b + 1;
		if (n < CMIN) n = CMIN;
		return 7'(n);
	endfunction

	task automatic serve_request(input func_t f, input logic [31:0] sz, input logic [7:0] fh,
			output outcome_t o);
		logic [6:0] c;
		logic [2:0] idx;
		logic [8:0] h;
		if (f == FUNC_ALLOC) begin
			c = size_to_class(sz);
			idx = 3'(int'(c) - CMIN);
			if (c <= CMAX && list_head[idx] != NULL_H) begin
				h = list_head[idx];
				list_head[idx] = next_link[h[7:0]];
				blk_held[h[7:0]] = 1'b1;
				o = '{ST_REUSED, h[7:0], c};
			end else begin
				// released handles go out before never-used ones
				if (spare_top != NULL_H) begin
					h = spare_top;
					spare_top = next_link[h[7:0]];
				end else if (fresh_next != NULL_H) begin
					h = fresh_next;
					fresh_next = fresh_next + 9'd1;
				end else begin
					h = NULL_H;
				end
				if (h == NULL_H) begin
					o = '{ST_NO_HANDLE, 8'd0, c};
				end else begin
					blk_class[h[7:0]] = c;
					blk_held[h[7:0]] = 1'b1;
					o = '{(c > CMAX) ? ST_LARGE : ST_NEW, h[7:0], c};
				end
			end
		end else begin
			if (!blk_held[fh]) begin
				o = '{ST_REJECT, fh, 7'd0};
			end else begin
				c = blk_class[fh];
				blk_held[fh] = 1'b0;
				if (c > CMAX || c < CMIN) begin
					next_link[fh] = spare_top;
					spare_top = {1'b0, fh};
					o = '{ST_LARGE, fh, c};
				end else begin
					idx = 3'(int'(c) - CMIN);
					next_link[fh] = list_head[idx];
					list_head[idx] = {1'b0, fh};
					o = '{ST_REUSED, fh, c};
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		outcome_t o;
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < NBLK; i++) begin
				next_link[i] = '0;
				blk_class[i] = '0;
				blk_held[i] = 1'b0;
			end
			for (int i = 0; i <= CMAX - CMIN; i++)
				list_head[i] = NULL_H;
			spare_top = NULL_H;
			fresh_next = '0;
			outcome_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (start && !busy) begin
				serve_request(func_t'(func), req_size, free_handle, o);
				outcome_q.push_back(o);
			end
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request outstanding: status %0d handle %0d class %0d",
						status, handle, size_class);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (handle !== want.handle) begin
						$error("handle: expected %0d, got %0d", want.handle, handle);
						errors++;
					end
					if (size_class !== want.cls) begin
						$error("size_class: expected %0d, got %0d", want.cls, size_class);
						errors++;
					end
				end
			end
			pending = outcome_q.size();
		end
	end

endmodule
`default_nettype wire

/* tb/size_class_block_recycler_test.sv */
// testbench top for the size class block recycler: clock, reset, requests and verdict
`default_nettype none
module size_class_block_recycler_test;
	import scbr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_LEN   = 275;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        func = 1'b0;
	logic [31:0] req_size = '0;
	logic [7:0]  free_handle = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  handle;
	logic [6:0]  size_class;
	int          pending;
	int          errors;

	int          cycles = 0;
	int          burst_left = 0;
	func_t       sent_q [$];
	func_t       kind;
	logic [7:0]  held_q [$];
	logic [7:0]  last_freed = 8'd0;
	int          n_req = 0, n_reused = 0, n_new = 0, n_large = 0, n_none = 0, n_reject = 0;
	int          alloc_pct [6] = '{60, 95, 20, 95, 15, 60};

	always #5 clk = ~clk;

	size_class_block_recycler u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.req_size    (req_size),
		.free_handle (free_handle),
		.done        (done),
		.status      (status),
		.handle      (handle),
		.size_class  (size_class)
	);

	size_class_block_recycler_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.req_size    (req_size),
		.free_handle (free_handle),
		.done        (done),
		.status      (status),
		.handle      (handle),
		.size_class  (size_class),
		.pending     (pending),
		.errors      (errors)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// remember granted handles so that random frees mostly hit live blocks
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sent_q.push_back(func_t'(func));
			n_req++;
		end
		if (arst_n && done && sent_q.size() != 0) begin
			kind = sent_q.pop_front();
			case (alloc_status_t'(status))
				ST_REUSED:    n_reused++;
				ST_NEW:       n_new++;
				ST_LARGE:     n_large++;
				ST_NO_HANDLE: n_none++;
				default:      n_reject++;
			endcase
			if (kind == FUNC_ALLOC && status inside {ST_REUSED, ST_NEW, ST_LARGE})
				held_q.push_back(handle);
		end
	end

	// called at a rising edge; returns at the edge that takes the request
	task automatic issue(input func_t f, input logic [31:0] sz, input logic [7:0] fh);
		start <= 1'b1;
		func <= f;
		req_size <= sz;
		free_handle <= fh;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic ask(input logic [31:0] sz);
		issue(FUNC_ALLOC, sz, 8'($urandom));
	endtask

	task automatic give(input logic [7:0] h);
		issue(FUNC_FREE, $urandom, h);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	function automatic logic [31:0] pick_size();
		int r;
		int c;
		r = $urandom_range(0, 99);
		if (r < 5) return 32'd0;
		if (r < 20) return 32'($urandom_range(1, 4096));
		if (r < 32) return $urandom;
		c = $urandom_range(13, 21);
		return (32'd1 << (c - 1)) + 32'($urandom_range(1, 1 << (c - 1)));
	endfunction

	function automatic logic [7:0] pick_free();
		int r;
		int idx;
		logic [7:0] h;
		r = $urandom_range(0, 99);
		if (r < 75 && held_q.size() != 0) begin
			idx = $urandom_range(0, held_q.size() - 1);
			h = held_q[idx];
			held_q.delete(idx);
			return h;
		end
		if (r < 85) return last_freed;
		return 8'($urandom);
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: class edges, large sizes, reuse, spare pool, bad frees
		ask(32'd0);
		ask(32'd1);
		ask(32'd4096);
		ask(32'd4097);
		ask(32'h0008_0000);
		ask(32'h0008_0001);
		ask(32'hFFFF_FFFF);
		ask(32'h8000_0000);
		give(8'd1);
		give(8'd1);
		give(8'd255);
		ask(32'd100);
		give(8'd0);
		ask(32'h0010_0000);
		give(8'd3);
		give(8'd4);
		ask(32'd8000);
		ask(32'h0007_FFFF);
		give(8'd2);
		give(8'd5);
		give(8'd6);
		give(8'd7);
		ask(32'd5000);
		ask(32'h4000_0001);
		drain();
		held_q.delete();
		held_q = '{8'd0, 8'd1, 8'd3, 8'd4, 8'd7, 8'd6};

		// random phases mix, fill and drain the handle pool twice, then mix again
		for (int p = 0; p < 6; p++) begin
			for (int i = 0; i < PHASE_LEN; i++) begin
				pace();
				if ($urandom_range(0, 99) < alloc_pct[p]) begin
					ask(pick_size());
				end else begin
					last_freed = pick_free();
					give(last_freed);
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d requests: %0d reused, %0d new, %0d large, %0d out of handles,",
			n_req, n_reused, n_new, n_large, n_none);
		$display("and %0d rejected frees across fill and drain phases", n_reject);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/scbr_pkg.sv
rtl/scbr_ram.sv
rtl/scbr_front.sv
rtl/scbr_queue.sv
rtl/scbr_back.sv
rtl/size_class_block_recycler.sv
tb/size_class_block_recycler_checker.sv
tb/size_class_block_recycler_test.sv
